@@ src/ttlsw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL table expiry sweep package
// Shared widths, request codes, reset values and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ttlsw_pkg;

  // Field widths.
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 8;
  localparam int TIME_W  = 64;
  localparam int GRACE_W = 40;
  localparam int COUNT_W = 9;

  // Default table depth.
  localparam int SLOTS_DEFAULT = 256;

  // Grace period after reset.
  localparam logic [GRACE_W-1:0] GRACE_RESET = 40'd10000000000;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SWEEP  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;   // clear the flags of the current slot, advance
    logic load_req;     // capture the request fields, reset the sweep state
    logic access;       // perform the captured write or remove
    logic sweep_step;   // read the current slot into the sweep pipeline
    logic report;       // load the sweep outcome into the result registers
    logic report_zero;  // load an all-zero result
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;     // slot counter points at the last slot
    logic pipe_empty;   // no slot in flight in the sweep pipeline
  } dp_stat_t;

endpackage

@@ src/ttlsw_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL table expiry sweep controller
// Sequences the clearing pass after reset, single-slot accesses and the
// table sweep, and drives the busy flag and the result strobe.
// ----------------------------------------------------------------------------
module ttlsw_ctrl
  import ttlsw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KIND_W-1:0] kind,
  input  dp_stat_t          stat,
  output ctl_cmd_t          cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_next   = (kind == KIND_SWEEP) ? ST_SWEEP : ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd.access      = 1'b1;
        cmd.report_zero = 1'b1;
        done_next       = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.idx_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          cmd.report = 1'b1;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
      done  <= done_next;
    end
  end

  // A result is only ever delivered with the block free for the next request.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // An accepted request always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // The sweep result is reported only once the pipeline has drained.
  a_report_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.report |-> stat.pipe_empty)
    else $error("sweep reported with slots in flight");

endmodule

@@ src/ttlsw_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL table expiry sweep datapath
// Holds the slot table in two memories, the grace period register, the
// sweep pipeline with its counters and minimum search, and the result
// registers.
// ----------------------------------------------------------------------------
module ttlsw_dp
  import ttlsw_pkg::*;
#(
  parameter int TABLE_SLOTS = SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  output dp_stat_t           stat,
  input  logic [KIND_W-1:0]  kind,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [TIME_W-1:0]  expiry_time,
  input  logic [TIME_W-1:0]  now,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [GRACE_W-1:0] cfg_data,
  output logic [TIME_W-1:0]  next_wake,
  output logic               has_next,
  output logic [COUNT_W-1:0] marked_count,
  output logic [COUNT_W-1:0] erased_count
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  // Flag memory entry: bit 1 valid, bit 0 expired.
  logic [1:0]        flag_mem [TABLE_SLOTS];
  logic [TIME_W-1:0] exp_mem  [TABLE_SLOTS];

  logic [GRACE_W-1:0] grace;
  logic [IDX_W-1:0]   idx;

  // Captured request.
  logic [KIND_W-1:0] kind_q;
  logic [SLOT_W-1:0] slot_q;
  logic [TIME_W-1:0] expiry_q;
  logic [TIME_W-1:0] now_q;

  // Stage 1: memory read data.
  logic              s1_v;
  logic [IDX_W-1:0]  s1_addr;
  logic [1:0]        s1_flags;
  logic [TIME_W-1:0] s1_exp;

  // Stage 2: compare, age and wake sum.
  logic              s2_v;
  logic [IDX_W-1:0]  s2_addr;
  logic [1:0]        s2_flags;
  logic [TIME_W-1:0] s2_exp;
  logic              s2_le;
  logic [TIME_W-1:0] s2_age;
  logic [TIME_W-1:0] s2_sum;

  // Stage 3: candidate wake time.
  logic              s3_v;
  logic              s3_remain;
  logic [TIME_W-1:0] s3_cand;

  // Sweep accumulators.
  logic               any;
  logic [TIME_W-1:0]  best;
  logic [COUNT_W-1:0] marked_cnt;
  logic [COUNT_W-1:0] erased_cnt;

  logic              in_range;
  logic [IDX_W-1:0]  slot_idx;
  logic [TIME_W-1:0] grace_ext;
  logic              s2_kill;
  logic              s2_mark;
  logic              s2_remain;
  logic              s2_exp_after;
  logic [TIME_W-1:0] s2_cand;

  assign grace_ext = {{(TIME_W-GRACE_W){1'b0}}, grace};
  assign in_range  = (32'(slot_q) < TABLE_SLOTS);
  assign slot_idx  = IDX_W'(slot_q);

  assign stat.idx_last   = (idx == IDX_W'(TABLE_SLOTS - 1));
  assign stat.pipe_empty = !s1_v && !s2_v && !s3_v;

  // Grace period register.
  always_ff @(posedge clk) begin
    if (rst) begin
      grace <= GRACE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      grace <= cfg_data;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_q   <= kind;
      slot_q   <= slot;
      expiry_q <= expiry_time;
      now_q    <= now;
    end
  end

  // Slot counter shared by the clearing pass and the sweep.
  always_ff @(posedge clk) begin
    if (rst || cmd.load_req) begin
      idx <= '0;
    end else if (cmd.clear_step || cmd.sweep_step) begin
      idx <= stat.idx_last ? '0 : idx + 1'b1;
    end
  end

  // Flag memory write port: clearing pass, access, or sweep write-back.
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      flag_mem[idx] <= 2'b00;
    end else if (cmd.access && in_range &&
                 (kind_q == KIND_WRITE || kind_q == KIND_REMOVE)) begin
      flag_mem[slot_idx] <= {(kind_q == KIND_WRITE), 1'b0};
    end else if (s2_v) begin
      flag_mem[s2_addr] <= {s2_remain, s2_remain && s2_exp_after};
    end
  end

  // Expiry memory write port.
  always_ff @(posedge clk) begin
    if (cmd.access && in_range && kind_q == KIND_WRITE) begin
      exp_mem[slot_idx] <= expiry_q;
    end
  end

  // Registered memory reads for the sweep.
  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      s1_flags <= flag_mem[idx];
      s1_exp   <= exp_mem[idx];
      s1_addr  <= idx;
    end
  end

  // Stage 2 arithmetic: expiry test, age since expiry, grace deadline.
  always_ff @(posedge clk) begin
    s2_addr  <= s1_addr;
    s2_flags <= s1_flags;
    s2_exp   <= s1_exp;
    s2_le    <= (s1_exp <= now_q);
    s2_age   <= now_q - s1_exp;
    s2_sum   <= s1_exp + grace_ext;
  end

  // Stage 2 decisions on the entry as it stood before the sweep.
  always_comb begin
    s2_kill      = s2_flags[1] && s2_flags[0] && (s2_age > grace_ext);
    s2_mark      = s2_flags[1] && !s2_flags[0] && s2_le;
    s2_remain    = s2_flags[1] && !s2_kill;
    s2_exp_after = s2_flags[0] || s2_mark;
    s2_cand      = s2_exp_after ? s2_sum : s2_exp;
  end

  always_ff @(posedge clk) begin
    s3_remain <= s2_remain;
    s3_cand   <= s2_cand;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= cmd.sweep_step;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  // Mark and erase counters.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      marked_cnt <= '0;
      erased_cnt <= '0;
    end else if (s2_v) begin
      marked_cnt <= marked_cnt + COUNT_W'(s2_mark);
      erased_cnt <= erased_cnt + COUNT_W'(s2_kill);
    end
  end

  // Running minimum of the wake times of remaining entries.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      any  <= 1'b0;
      best <= '0;
    end else if (s3_v && s3_remain) begin
      any <= 1'b1;
      if (!any || s3_cand < best) begin
        best <= s3_cand;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      next_wake    <= any ? best : '0;
      has_next     <= any;
      marked_count <= marked_cnt;
      erased_count <= erased_cnt;
    end else if (cmd.report_zero) begin
      next_wake    <= '0;
      has_next     <= 1'b0;
      marked_count <= '0;
      erased_count <= '0;
    end
  end

  // Slots move through the sweep pipeline one stage per cycle.
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    s3_v |-> $past(s1_v, 2))
    else $error("sweep pipeline stage skipped");

  // No single-slot access overlaps a sweep in flight.
  a_access_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    cmd.access |-> stat.pipe_empty)
    else $error("slot access during sweep");

endmodule

@@ src/ttl_table_expiry_sweep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL table expiry sweep
// Table of timed slots with write, remove and an aging sweep that marks
// expired entries, erases those past the grace period and reports the
// earliest pending wake time.
// ----------------------------------------------------------------------------
// After reset the block clears the table flags one slot per cycle, keeping
// busy high until every slot is cleared; the grace period register can be
// written during that time. A request is taken when start is high and busy
// is low. A write or remove passes through the access state to its result
// strobe. A sweep reads each slot once through one memory port and the
// sweep pipeline; its result strobe comes once the pipeline has drained.
// Every request yields exactly one result, shown for one
// cycle with done high; the receiver must take it then, as it cannot stall
// the block. A new request may be started in the cycle that done is high.
module ttl_table_expiry_sweep
  import ttlsw_pkg::*;
#(
  parameter int TABLE_SLOTS = SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  kind,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [TIME_W-1:0]  expiry_time,
  input  logic [TIME_W-1:0]  now,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [GRACE_W-1:0] cfg_data,
  output logic               done,
  output logic [TIME_W-1:0]  next_wake,
  output logic               has_next,
  output logic [COUNT_W-1:0] marked_count,
  output logic [COUNT_W-1:0] erased_count
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // The grace period register accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  // Sequencer.
  ttlsw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Table storage and sweep pipeline.
  ttlsw_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .slot         (slot),
    .expiry_time  (expiry_time),
    .now          (now),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .next_wake    (next_wake),
    .has_next     (has_next),
    .marked_count (marked_count),
    .erased_count (erased_count)
  );

endmodule

@@ verif/tb_ttl_table_expiry_sweep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL table expiry sweep testbench
// Drives write, remove, sweep and unused requests into the table and checks
// every result strobe against a hand-written result or a cycle-free model of
// the slot table. A short table of directed requests comes first, then random
// request phases, each under its own grace period loaded with the block idle.
// ----------------------------------------------------------------------------
module tb_ttl_table_expiry_sweep;
  import ttlsw_pkg::*;

  localparam int TABLE_SLOTS   = SLOTS_DEFAULT;
  localparam int NUM_DIRECTED  = 24;
  localparam int RANDOM_ITEMS  = 950;

  // The package names three kinds; the fourth code is accepted and ignored.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [TIME_W-1:0] MAX_T         = '1;
  localparam logic [TIME_W-1:0] RESET_GRACE_T = 64'd10000000000;

  // One result of the block.
  typedef struct packed {
    logic [TIME_W-1:0]  next_wake;
    logic               has_next;
    logic [COUNT_W-1:0] marked;
    logic [COUNT_W-1:0] erased;
  } wake_result_t;

  localparam wake_result_t NO_WAKE = '0;

  // One row of directed stimulus, with an optional hand-written result.
  typedef struct packed {
    logic [KIND_W-1:0] req_kind;
    logic [SLOT_W-1:0] req_slot;
    logic [TIME_W-1:0] req_expiry;
    logic [TIME_W-1:0] req_now;
    logic              typed;
    wake_result_t      outcome;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [KIND_W-1:0]  kind = KIND_WRITE;
  logic [SLOT_W-1:0]  slot = '0;
  logic [TIME_W-1:0]  expiry_time = '0;
  logic [TIME_W-1:0]  now = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [GRACE_W-1:0] cfg_data = '0;
  logic               done;
  logic [TIME_W-1:0]  next_wake;
  logic               has_next;
  logic [COUNT_W-1:0] marked_count;
  logic [COUNT_W-1:0] erased_count;

  // Shadow copy of the slot table and the grace period register.
  logic               slot_live   [TABLE_SLOTS];
  logic               slot_aged   [TABLE_SLOTS];
  logic [TIME_W-1:0]  slot_expiry [TABLE_SLOTS];
  logic [GRACE_W-1:0] grace_model = GRACE_RESET;

  wake_result_t pending_outcomes [$];
  wake_result_t want_r;
  stim_row_t    directed_rows [NUM_DIRECTED];
  int           mismatch_count = 0;

  ttl_table_expiry_sweep u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .slot         (slot),
    .expiry_time  (expiry_time),
    .now          (now),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .next_wake    (next_wake),
    .has_next     (has_next),
    .marked_count (marked_count),
    .erased_count (erased_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_live[i]   = 1'b0;
      slot_aged[i]   = 1'b0;
      slot_expiry[i] = '0;
    end
  end

  // Applies one request to the shadow table and returns the result it yields.
  function automatic wake_result_t apply_table_request(
    input logic [KIND_W-1:0] req_kind,
    input logic [SLOT_W-1:0] req_slot,
    input logic [TIME_W-1:0] req_expiry,
    input logic [TIME_W-1:0] req_now
  );
    wake_result_t      res;
    bit                to_mark  [TABLE_SLOTS];
    bit                to_erase [TABLE_SLOTS];
    logic [TIME_W-1:0] wake;
    logic [TIME_W-1:0] grace_t;
    res = NO_WAKE;
    grace_t = {{(TIME_W-GRACE_W){1'b0}}, grace_model};
    case (req_kind)
      KIND_WRITE: begin
        if (req_slot < TABLE_SLOTS) begin
          slot_live[req_slot]   = 1'b1;
          slot_aged[req_slot]   = 1'b0;
          slot_expiry[req_slot] = req_expiry;
        end
      end
      KIND_REMOVE: begin
        if (req_slot < TABLE_SLOTS) begin
          slot_live[req_slot] = 1'b0;
          slot_aged[req_slot] = 1'b0;
        end
      end
      KIND_SWEEP: begin
        // Both decisions are taken from the table as it stands.
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          to_mark[i]  = 1'b0;
          to_erase[i] = 1'b0;
          if (slot_live[i]) begin
            if (slot_aged[i]) begin
              to_erase[i] = (req_now - slot_expiry[i]) > grace_t;
            end else begin
              to_mark[i] = slot_expiry[i] <= req_now;
            end
          end
        end
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (to_mark[i]) begin
            slot_aged[i] = 1'b1;
            res.marked++;
          end
          if (to_erase[i]) begin
            slot_live[i] = 1'b0;
            slot_aged[i] = 1'b0;
            res.erased++;
          end
        end
        // Expired entries wake at the end of their grace period, modulo 2^64.
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (slot_live[i]) begin
            wake = slot_aged[i] ? slot_expiry[i] + grace_t : slot_expiry[i];
            if (!res.has_next || wake < res.next_wake) begin
              res.next_wake = wake;
            end
            res.has_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TIME_W-1:0] rand_upto(input logic [TIME_W-1:0] lim);
    if (lim == MAX_T) begin
      return rand64();
    end
    return rand64() % (lim + 64'd1);
  endfunction

  // Presents one request after an optional idle gap and records its expected result.
  task automatic send_request(
    input logic [KIND_W-1:0] req_kind,
    input logic [SLOT_W-1:0] req_slot,
    input logic [TIME_W-1:0] req_expiry,
    input logic [TIME_W-1:0] req_now,
    input int                gap,
    input logic              typed,
    input wake_result_t      typed_r
  );
    wake_result_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    kind        <= req_kind;
    slot        <= req_slot;
    expiry_time <= req_expiry;
    now         <= req_now;
    do @(posedge clk); while (busy);
    predicted = apply_table_request(req_kind, req_slot, req_expiry, req_now);
    pending_outcomes.push_back(typed ? typed_r : predicted);
  endtask

  // Stops issuing requests until every expected result has come back.
  task automatic wait_for_outcomes();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Loads a new grace period once the block has gone idle.
  task automatic load_grace(input logic [GRACE_W-1:0] value);
    wait_for_outcomes();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    grace_model = value;
  endtask

  // Each result strobe is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected: next_wake %h has_next %b marked %0d erased %0d",
                 $time, next_wake, has_next, marked_count, erased_count);
        mismatch_count++;
      end else begin
        want_r = pending_outcomes.pop_front();
        if (next_wake !== want_r.next_wake) begin
          $display("%0t: next_wake mismatch: expected %h, actual %h",
                   $time, want_r.next_wake, next_wake);
          mismatch_count++;
        end
        if (has_next !== want_r.has_next) begin
          $display("%0t: has_next mismatch: expected %b, actual %b",
                   $time, want_r.has_next, has_next);
          mismatch_count++;
        end
        if (marked_count !== want_r.marked) begin
          $display("%0t: marked_count mismatch: expected %0d, actual %0d",
                   $time, want_r.marked, marked_count);
          mismatch_count++;
        end
        if (erased_count !== want_r.erased) begin
          $display("%0t: erased_count mismatch: expected %0d, actual %0d",
                   $time, want_r.erased, erased_count);
          mismatch_count++;
        end
      end
    end
  end

  // Directed requests, all under the grace period left by reset.
  initial begin
    directed_rows = '{
      // Sweep of the empty table after reset.
      '{KIND_SWEEP,  8'd0,   64'd0,     64'd0, 1'b1, NO_WAKE},
      '{KIND_WRITE,  8'd0,   64'd0,     64'd0, 1'b1, NO_WAKE},
      '{KIND_WRITE,  8'd255, MAX_T,     64'd0, 1'b1, NO_WAKE},
      '{KIND_WRITE,  8'd10,  64'd1000,  64'd0, 1'b1, NO_WAKE},
      '{KIND_SWEEP,  8'd0,   64'd0,     64'd0, 1'b1, '{64'd1000, 1'b1, 9'd1, 9'd0}},
      // The unused kind must leave the table alone.
      '{KIND_UNUSED, 8'd10,  MAX_T,     MAX_T, 1'b1, NO_WAKE},
      '{KIND_REMOVE, 8'd10,  64'd0,     64'd0, 1'b1, NO_WAKE},
      '{KIND_REMOVE, 8'd10,  64'd0,     64'd0, 1'b1, NO_WAKE},
      '{KIND_SWEEP,  8'd0,   64'd0,     64'd5, 1'b1, '{RESET_GRACE_T, 1'b1, 9'd0, 9'd0}},
      // Rewriting an expired slot clears its expired mark.
      '{KIND_WRITE,  8'd0,   64'd100,   64'd0, 1'b1, NO_WAKE},
      '{KIND_SWEEP,  8'd0,   64'd0,     64'd50, 1'b1, '{64'd100, 1'b1, 9'd0, 9'd0}},
      '{KIND_SWEEP,  8'd0,   64'd0,     64'd100, 1'b1,
        '{64'd10000000100, 1'b1, 9'd1, 9'd0}},
      // An age equal to the grace period keeps the entry; one more erases it.
      '{KIND_SWEEP,  8'd0,   64'd0,     64'd10000000100, 1'b1,
        '{64'd10000000100, 1'b1, 9'd0, 9'd0}},
      '{KIND_SWEEP,  8'd0,   64'd0,     64'd10000000101, 1'b1, '{MAX_T, 1'b1, 9'd0, 9'd1}},
      '{KIND_WRITE,  8'd7,   64'd0,     64'd0, 1'b1, NO_WAKE},
      '{KIND_WRITE,  8'd128, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0, 1'b1, NO_WAKE},
      // Old entries are marked here but not erased in the same sweep.
      '{KIND_SWEEP,  8'd0,   64'd0,     MAX_T, 1'b0, NO_WAKE},
      '{KIND_WRITE,  8'd64,  64'h5555_5555_5555_5555, 64'd0, 1'b1, NO_WAKE},
      // Time wrap: an expiry well after now looks very old and is erased.
      '{KIND_SWEEP,  8'd0,   64'd0,     64'd0, 1'b0, NO_WAKE},
      '{KIND_REMOVE, 8'd255, 64'd0,     64'd0, 1'b1, NO_WAKE},
      '{KIND_REMOVE, 8'd7,   64'd0,     64'd0, 1'b1, NO_WAKE},
      '{KIND_REMOVE, 8'd64,  64'd0,     64'd0, 1'b1, NO_WAKE},
      '{KIND_SWEEP,  8'd0,   64'd0,     64'd0, 1'b1, NO_WAKE},
      '{KIND_UNUSED, 8'd0,   64'd0,     64'd0, 1'b1, NO_WAKE}
    };
  end

  initial begin
    int                 gap;
    int                 sent;
    int                 phase;
    int                 phase_len;
    int                 pick;
    int                 slot_hi;
    bit                 quiet;
    logic [GRACE_W-1:0] grace_v;
    logic [TIME_W-1:0]  span;
    logic [TIME_W-1:0]  t_now;
    logic [TIME_W-1:0]  e_t;
    logic [TIME_W-1:0]  n_t;
    logic [SLOT_W-1:0]  s_v;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_request(directed_rows[r].req_kind, directed_rows[r].req_slot,
                   directed_rows[r].req_expiry, directed_rows[r].req_now,
                   $urandom_range(0, 8), directed_rows[r].typed,
                   directed_rows[r].outcome);
    end

    // Random phases; the first four use extreme, 1000 and reset grace periods.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: grace_v = '0;
        1: grace_v = '1;
        2: grace_v = 40'd1000;
        3: grace_v = GRACE_RESET;
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            grace_v = 40'($urandom_range(0, 1 << 20));
          end else begin
            grace_v = {8'($urandom), 32'($urandom)};
          end
        end
      endcase
      load_grace(grace_v);

      span = (grace_v == '0) ? 64'($urandom_range(1, 5000))
                             : {{(TIME_W-GRACE_W){1'b0}}, grace_v} + 64'd1;
      if ($urandom_range(0, 2) == 0) begin
        t_now = MAX_T - rand_upto(span << 2);
      end else begin
        t_now = rand64();
      end
      case ($urandom_range(0, 2))
        0:       slot_hi = 15;
        1:       slot_hi = 63;
        default: slot_hi = TABLE_SLOTS - 1;
      endcase
      quiet = ($urandom_range(0, 2) == 0);

      // Fill every slot, mark them all, then erase them all.
      if (phase == 2) begin
        t_now = rand64() >> 1;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          send_request(KIND_WRITE, 8'(i), t_now + rand_upto(span), rand64(),
                       quiet ? 0 : $urandom_range(0, 8), 1'b0, NO_WAKE);
        end
        t_now = t_now + span;
        send_request(KIND_SWEEP, 8'($urandom), rand64(), t_now,
                     quiet ? 0 : $urandom_range(0, 8), 1'b0, NO_WAKE);
        t_now = t_now + span + {{(TIME_W-GRACE_W){1'b0}}, grace_v} + 64'd1;
        send_request(KIND_SWEEP, 8'($urandom), rand64(), t_now,
                     quiet ? 0 : $urandom_range(0, 8), 1'b0, NO_WAKE);
        sent += TABLE_SLOTS + 2;
      end

      phase_len = $urandom_range(100, 200);
      for (int k = 0; k < phase_len; k++) begin
        gap = quiet ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 49) == 0) begin
          wait_for_outcomes();
        end
        pick = $urandom_range(0, 99);
        s_v  = 8'($urandom_range(0, slot_hi));
        if (pick < 40) begin
          // Mostly expiries around the current time, sometimes anywhere.
          e_t = ($urandom_range(0, 9) == 0) ? rand64() : t_now + rand_upto(span << 1);
          send_request(KIND_WRITE, s_v, e_t, rand64(), gap, 1'b0, NO_WAKE);
          sent++;
        end else if (pick < 55) begin
          send_request(KIND_REMOVE, s_v, rand64(), rand64(), gap, 1'b0, NO_WAKE);
          sent++;
        end else if (pick < 90) begin
          // Time mostly moves forward; now and then a sweep looks back or jumps.
          case ($urandom_range(0, 19))
            0:       n_t = rand64();
            1:       n_t = t_now - rand_upto(span);
            default: begin
              t_now = t_now + rand_upto(span);
              n_t   = t_now;
            end
          endcase
          send_request(KIND_SWEEP, s_v, rand64(), n_t, gap, 1'b0, NO_WAKE);
          sent++;
        end else if (pick < 95) begin
          send_request(KIND_UNUSED, 8'($urandom), rand64(), rand64(), gap, 1'b0, NO_WAKE);
        end else begin
          // An entry written already in the past.
          e_t = t_now - rand_upto(span << 1);
          send_request(KIND_WRITE, s_v, e_t, rand64(), gap, 1'b0, NO_WAKE);
          sent++;
        end
      end
      phase++;
    end

    wait_for_outcomes();
    repeat (TABLE_SLOTS + 40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #25ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
